[rtl/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and constants shared by the cartridge bank controller modules.
// ----------------------------------------------------------------------------
package cbc_pkg;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MBC1_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_BATTERY_PRESENT = 2'd1;
    localparam logic [1:0] CFG_RAM_SIZE_CODE   = 2'd2;

    // Bus regions, taken from address bits 15:13.
    localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
    localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
    localparam logic [2:0] REGION_RAM_BANK   = 3'd2;
    localparam logic [2:0] REGION_MODE       = 3'd3;
    localparam logic [2:0] REGION_RAM        = 3'd5;

    // Header RAM size codes.
    localparam logic [7:0] RAM_CODE_ONE_BANK  = 8'd2;
    localparam logic [7:0] RAM_CODE_4_BANKS   = 8'd3;
    localparam logic [7:0] RAM_CODE_16_BANKS  = 8'd4;
    localparam logic [7:0] RAM_CODE_8_BANKS   = 8'd5;

    localparam logic [3:0]  RAM_ENABLE_KEY   = 4'hA;
    localparam logic [7:0]  OPEN_BUS_DATA    = 8'hFF;
    localparam logic [19:0] ROM_BANK_BASE    = 20'h04000;
    localparam int          RAM_BANK_BYTES   = 8192;
    localparam int          RAM_OFFSET_W     = 13;
    localparam int          ROM_BANK_BITS    = 5;

    typedef struct packed {
        logic        opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_fetch;
        logic [19:0] rom_address;
        logic        save_request;
        logic        need_save;
    } out_item_t;

    // Result fields known at decode time; the RAM byte joins them at the output register.
    typedef struct packed {
        logic        use_ram;
        logic [7:0]  fixed_data;
        logic        rom_fetch;
        logic [19:0] rom_address;
        logic        save_request;
        logic        need_save;
    } cbc_meta_t;

    typedef struct packed {
        logic      ram_read;
        logic      ram_write;
        cbc_meta_t meta;
    } cbc_access_t;

endpackage

[rtl/cbc_mapper.sv]
// ----------------------------------------------------------------------------
// cbc_mapper
// Bank registers, configuration registers and access decode.
// ----------------------------------------------------------------------------
module cbc_mapper #(
    parameter int RAM_BANK_COUNT = 4,
    parameter int RAM_ADDR_W     = 15
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write_en,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_wdata,
    input  logic                  acc_valid,
    input  cbc_pkg::in_item_t     item,
    output cbc_pkg::cbc_access_t  access,
    output logic [RAM_ADDR_W-1:0] mem_index
);

    logic       mbc1_enable_reg;
    logic       battery_reg;
    logic [7:0] ram_code_reg;

    logic       ram_en_reg,      ram_en_next;
    logic [4:0] rom_bank_reg,    rom_bank_next;
    logic [1:0] ram_sel_reg,     ram_sel_next;
    logic       mode_reg,        mode_next;
    logic [1:0] active_bank_reg, active_bank_next;
    logic       dirty_reg,       dirty_next;

    logic [2:0]  region;
    logic        is_write;
    logic        bank_exists;
    logic        bank_ok;
    logic [4:0]  wr_rom_bank;
    logic [19:0] banked_address;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbc1_enable_reg <= 1'b0;
            battery_reg     <= 1'b0;
            ram_code_reg    <= 8'd0;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                cbc_pkg::CFG_MBC1_ENABLE:     mbc1_enable_reg <= cfg_wdata[0];
                cbc_pkg::CFG_BATTERY_PRESENT: battery_reg     <= cfg_wdata[0];
                cbc_pkg::CFG_RAM_SIZE_CODE:   ram_code_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign region   = item.address[15:13];
    assign is_write = (item.opcode == cbc_pkg::OP_WRITE);

    // Codes that offer more than one bank cover every bank below RAM_BANK_COUNT.
    always_comb begin
        bank_exists = 1'b0;
        if ({3'b000, active_bank_reg} < 5'(RAM_BANK_COUNT)) begin
            bank_exists = (ram_code_reg == cbc_pkg::RAM_CODE_ONE_BANK &&
                           active_bank_reg == 2'd0) ||
                          ram_code_reg == cbc_pkg::RAM_CODE_4_BANKS ||
                          ram_code_reg == cbc_pkg::RAM_CODE_16_BANKS ||
                          ram_code_reg == cbc_pkg::RAM_CODE_8_BANKS;
        end
    end

    assign bank_ok        = ram_en_reg && bank_exists;
    assign wr_rom_bank    = (item.write_data[4:0] == 5'd0) ? 5'd1 : item.write_data[4:0];
    assign banked_address = {1'b0, rom_bank_reg, 14'd0} + {4'd0, item.address}
                          - cbc_pkg::ROM_BANK_BASE;
    assign mem_index      = RAM_ADDR_W'({active_bank_reg,
                                         item.address[cbc_pkg::RAM_OFFSET_W-1:0]});

    always_comb begin
        ram_en_next      = ram_en_reg;
        rom_bank_next    = rom_bank_reg;
        ram_sel_next     = ram_sel_reg;
        mode_next        = mode_reg;
        active_bank_next = active_bank_reg;
        dirty_next       = dirty_reg;
        access           = '0;

        if (!is_write) begin
            if (!mbc1_enable_reg || item.address[15:14] == 2'b00) begin
                access.meta.rom_fetch   = 1'b1;
                access.meta.rom_address = {4'd0, item.address};
            end else if (region == cbc_pkg::REGION_RAM) begin
                if (bank_ok) begin
                    access.ram_read     = 1'b1;
                    access.meta.use_ram = 1'b1;
                end else begin
                    access.meta.fixed_data = cbc_pkg::OPEN_BUS_DATA;
                end
            end else begin
                access.meta.rom_fetch   = 1'b1;
                access.meta.rom_address = banked_address;
            end
        end else if (mbc1_enable_reg) begin
            unique case (region)
                cbc_pkg::REGION_RAM_ENABLE: begin
                    ram_en_next = (item.write_data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                end
                cbc_pkg::REGION_ROM_BANK: begin
                    rom_bank_next = wr_rom_bank;
                end
                cbc_pkg::REGION_RAM_BANK: begin
                    ram_sel_next = item.write_data[1:0];
                    if (mode_reg) begin
                        access.meta.save_request = dirty_reg;
                        active_bank_next         = item.write_data[1:0];
                    end
                end
                cbc_pkg::REGION_MODE: begin
                    mode_next = item.write_data[0];
                    if (item.write_data[0]) begin
                        access.meta.save_request = dirty_reg;
                        active_bank_next         = ram_sel_reg;
                    end
                end
                cbc_pkg::REGION_RAM: begin
                    if (bank_ok) begin
                        access.ram_write = 1'b1;
                        if (battery_reg) begin
                            dirty_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        access.meta.need_save = dirty_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_en_reg      <= 1'b0;
            rom_bank_reg    <= 5'd1;
            ram_sel_reg     <= 2'd0;
            mode_reg        <= 1'b0;
            active_bank_reg <= 2'd0;
            dirty_reg       <= 1'b0;
        end else if (acc_valid) begin
            ram_en_reg      <= ram_en_next;
            rom_bank_reg    <= rom_bank_next;
            ram_sel_reg     <= ram_sel_next;
            mode_reg        <= mode_next;
            active_bank_reg <= active_bank_next;
            dirty_reg       <= dirty_next;
        end
    end

endmodule

[rtl/cartridge_bank_controller.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Banked cartridge controller: maps ROM reads, serves the battery RAM window
// and keeps the bank registers.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   cfg       in         cfg_write_en          cfg_index, cfg_wdata
//   s_        in         s_valid / s_ready     s_data (in_item_t)
//   m_        out        m_valid / m_ready     m_data (out_item_t)
//
// One item is taken per cycle while s_ready is high; its result passes through the
// stage-1 register (with the registered RAM read) and then the output register.
// After reset the RAM is cleared one byte per cycle, all RAM_BANK_COUNT * 8192
// bytes (32768 by default), with s_ready low; configuration writes are taken.
// When m_ready is low the result holds, one more item can enter, then s_ready drops.
// ----------------------------------------------------------------------------
module cartridge_bank_controller #(
    parameter int RAM_BANK_COUNT = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  cbc_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cbc_pkg::out_item_t  m_data
);

    localparam int RAM_DEPTH  = RAM_BANK_COUNT * cbc_pkg::RAM_BANK_BYTES;
    localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

    cbc_pkg::cbc_access_t  access;
    logic [RAM_ADDR_W-1:0] mem_index;
    logic                  s_accept;

    logic [7:0]            ram_mem [RAM_DEPTH];
    logic [7:0]            ram_rdata_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [RAM_ADDR_W-1:0] mem_waddr;
    logic [7:0]            mem_wdata;

    logic                  clear_active_reg, clear_active_next;
    logic [RAM_ADDR_W-1:0] clr_idx_reg,      clr_idx_next;
    logic                  clr_last;

    logic                  s1_valid_reg, s1_valid_next;
    cbc_pkg::cbc_meta_t    s1_meta_reg;
    logic                  s1_move;
    logic                  m_valid_reg, m_valid_next;
    cbc_pkg::out_item_t    m_data_reg;

    cbc_mapper #(
        .RAM_BANK_COUNT (RAM_BANK_COUNT),
        .RAM_ADDR_W     (RAM_ADDR_W)
    ) u_mapper (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .acc_valid    (s_accept),
        .item         (s_data),
        .access       (access),
        .mem_index    (mem_index)
    );

    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clear_active_reg && (!s1_valid_reg || s1_move);
    assign s_accept = s_valid && s_ready;

    // The clearing pass owns the write port until it ends; no item is taken meanwhile.
    assign clr_last  = (clr_idx_reg == RAM_ADDR_W'(RAM_DEPTH - 1));
    assign mem_we    = clear_active_reg || (s_accept && access.ram_write);
    assign mem_waddr = clear_active_reg ? clr_idx_reg : mem_index;
    assign mem_wdata = clear_active_reg ? 8'h00 : s_data.write_data;
    assign mem_re    = s_accept && access.ram_read;

    // Read data only changes on a new read, so a stalled item keeps its byte.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ram_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            ram_rdata_reg <= ram_mem[mem_index];
        end
    end

    always_comb begin
        clear_active_next = clear_active_reg && !clr_last;
        clr_idx_next      = clr_idx_reg;
        if (clear_active_reg && !clr_last) begin
            clr_idx_next = clr_idx_reg + RAM_ADDR_W'(1);
        end
        s1_valid_next = s_accept || (s1_valid_reg && !s1_move);
        m_valid_next  = s1_move || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clr_idx_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            clear_active_reg <= clear_active_next;
            clr_idx_reg      <= clr_idx_next;
            s1_valid_reg     <= s1_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_meta_reg <= access.meta;
        end
        if (s1_move) begin
            m_data_reg.read_data    <= s1_meta_reg.use_ram ? ram_rdata_reg
                                                           : s1_meta_reg.fixed_data;
            m_data_reg.rom_fetch    <= s1_meta_reg.rom_fetch;
            m_data_reg.rom_address  <= s1_meta_reg.rom_address;
            m_data_reg.save_request <= s1_meta_reg.save_request;
            m_data_reg.need_save    <= s1_meta_reg.need_save;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[tb/sv/cartridge_bank_controller_test.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_controller_test
// Self-checking bench for the banked cartridge controller. Bus accesses are
// queued, driven with random gaps and checked against an in-bench model of the
// bank registers and the battery RAM, under several register settings.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbc_pkg::*;

    localparam int RAM_BANKS   = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    // Model of the controller: settings, bank registers and battery RAM.
    logic        mbc_on = 1'b0;
    logic        battery_on = 1'b0;
    logic [7:0]  ram_code = '0;
    logic        ram_on = 1'b0;
    logic [4:0]  rom_bank_reg = 5'd1;
    logic [1:0]  bank_pick = '0;
    logic        mode_bit = 1'b0;
    logic [1:0]  active_bank = '0;
    logic        dirty = 1'b0;
    logic [7:0]  ram_image [0:RAM_BANKS*RAM_BANK_BYTES-1];

    in_item_t    pending_items[$];
    out_item_t   expected_results[$];

    logic        took_item = 1'b0;
    logic        idle_on = 1'b1;
    int          send_gap = 0;
    int          stall_left = 0;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          accesses_taken = 0;
    int          results_checked = 0;
    int          saves_seen = 0;
    int          settings_used = 0;
    int          errors = 0;
    int          cycle_count = 0;

    cartridge_bank_controller u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic bank_present(logic [1:0] bank);
        int avail;
        case (ram_code)
            RAM_CODE_ONE_BANK: avail = 1;
            RAM_CODE_4_BANKS:  avail = 4;
            RAM_CODE_16_BANKS: avail = 16;
            RAM_CODE_8_BANKS:  avail = 8;
            default:           avail = 0;
        endcase
        return (int'(bank) < avail) && (int'(bank) < RAM_BANKS);
    endfunction

    // Applies one access to the model and returns the result it must produce.
    function automatic out_item_t predict_access(in_item_t acc);
        out_item_t   res;
        logic [2:0]  region;
        int unsigned mapped;
        res = '0;
        region = acc.address[15:13];
        if (acc.opcode == OP_READ) begin
            if (!mbc_on || acc.address < 16'h4000) begin
                res.rom_fetch = 1'b1;
                res.rom_address = {4'h0, acc.address};
            end else if (region == REGION_RAM) begin
                if (ram_on && bank_present(active_bank))
                    res.read_data = ram_image[{active_bank, acc.address[12:0]}];
                else
                    res.read_data = OPEN_BUS_DATA;
            end else begin
                res.rom_fetch = 1'b1;
                mapped = rom_bank_reg * ROM_BANK_BASE + acc.address - ROM_BANK_BASE;
                res.rom_address = mapped[19:0];
            end
        end else if (mbc_on) begin
            case (region)
                REGION_RAM_ENABLE: begin
                    ram_on = (acc.write_data[3:0] == RAM_ENABLE_KEY);
                end
                REGION_ROM_BANK: begin
                    rom_bank_reg = acc.write_data[ROM_BANK_BITS-1:0];
                    if (rom_bank_reg == 5'd0)
                        rom_bank_reg = 5'd1;
                end
                REGION_RAM_BANK, REGION_MODE: begin
                    if (region == REGION_RAM_BANK)
                        bank_pick = acc.write_data[1:0];
                    else
                        mode_bit = acc.write_data[0];
                    // Only mode 1 moves the recorded selection into the active bank.
                    if (mode_bit) begin
                        res.save_request = dirty;
                        active_bank = bank_pick;
                    end
                end
                REGION_RAM: begin
                    if (ram_on && bank_present(active_bank)) begin
                        ram_image[{active_bank, acc.address[12:0]}] = acc.write_data;
                        if (battery_on)
                            dirty = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res.need_save = dirty;
        return res;
    endfunction

    // Input side: take note of accepted items and predict their results.
    always @(posedge aclk) begin
        took_item <= s_valid && s_ready;
        if (s_valid && s_ready) begin
            expected_results.push_back(predict_access(s_data));
            accesses_taken++;
        end
    end

    // Driver: offers the queued items with random gaps between them.
    always @(negedge aclk) begin
        if (!s_valid || took_item) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                send_gap = int'($urandom_range(1, 13)) - 1;
                s_valid <= 1'b0;
            end else if (aresetn && pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is asked for.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            stall_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(1, 13)) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: each result is matched against the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (m_valid && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("result with no access waiting: %h", m_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want.save_request)
                    saves_seen++;
                if (m_data.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, m_data.read_data);
                    errors++;
                end
                if (m_data.rom_fetch !== want.rom_fetch) begin
                    $error("rom_fetch: expected %b, got %b", want.rom_fetch, m_data.rom_fetch);
                    errors++;
                end
                if (m_data.rom_address !== want.rom_address) begin
                    $error("rom_address: expected %h, got %h",
                           want.rom_address, m_data.rom_address);
                    errors++;
                end
                if (m_data.save_request !== want.save_request) begin
                    $error("save_request: expected %b, got %b",
                           want.save_request, m_data.save_request);
                    errors++;
                end
                if (m_data.need_save !== want.need_save) begin
                    $error("need_save: expected %b, got %b", want.need_save, m_data.need_save);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic set_register(logic [1:0] index, logic [7:0] value);
        @(negedge aclk);
        cfg_write_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            CFG_MBC1_ENABLE:     mbc_on = value[0];
            CFG_BATTERY_PRESENT: battery_on = value[0];
            CFG_RAM_SIZE_CODE:   ram_code = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic queue_access(logic op, logic [15:0] addr, logic [7:0] data);
        in_item_t acc;
        acc.opcode = op;
        acc.address = addr;
        acc.write_data = data;
        pending_items.push_back(acc);
    endtask

    // Mostly accesses aimed at the control areas and the RAM window, so that
    // the RAM gets enabled and written and later reads find the data again.
    task automatic queue_random_accesses(int count);
        in_item_t acc;
        int       pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            acc.opcode = OP_WRITE;
            acc.address = 16'($urandom_range(0, 65535));
            acc.write_data = 8'($urandom_range(0, 255));
            if (pick < 12) begin
                acc.address[15:13] = REGION_RAM_ENABLE;
                if ($urandom_range(0, 3) != 0)
                    acc.write_data[3:0] = RAM_ENABLE_KEY;
            end else if (pick < 20) begin
                acc.address[15:13] = REGION_ROM_BANK;
            end else if (pick < 28) begin
                acc.address[15:13] = REGION_RAM_BANK;
            end else if (pick < 34) begin
                acc.address[15:13] = REGION_MODE;
            end else if (pick < 84) begin
                if (pick >= 58)
                    acc.opcode = OP_READ;
                acc.address[15:13] = REGION_RAM;
                if ($urandom_range(0, 1) == 0)
                    acc.address[12:4] = '0;
            end else if (pick < 94) begin
                acc.opcode = OP_READ;
            end else begin
                acc.opcode = 1'($urandom_range(0, 1));
            end
            pending_items.push_back(acc);
        end
    endtask

    // Waits until every queued item has been sent and every predicted result checked.
    task automatic wait_for_drain();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(logic mbc, logic battery, logic [7:0] code, int count,
                             logic idling, logic long_hold);
        wait_for_drain();
        idle_on = idling;
        set_register(CFG_MBC1_ENABLE, {7'd0, mbc});
        set_register(CFG_BATTERY_PRESENT, {7'd0, battery});
        set_register(CFG_RAM_SIZE_CODE, code);
        settings_used++;
        queue_random_accesses(count);
        if (long_hold)
            holds_asked++;
    endtask

    initial begin
        for (int i = 0; i < RAM_BANKS * RAM_BANK_BYTES; i++)
            ram_image[i] = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The block is still clearing its RAM here, and register writes are taken.
        set_register(CFG_MBC1_ENABLE, 8'd1);
        set_register(CFG_BATTERY_PRESENT, 8'd1);
        set_register(CFG_RAM_SIZE_CODE, RAM_CODE_4_BANKS);
        settings_used++;

        queue_access(OP_READ,  16'h0000, 8'h00);
        queue_access(OP_READ,  16'h3FFF, 8'hFF);
        queue_access(OP_READ,  16'h4000, 8'h00);
        queue_access(OP_READ,  16'h7FFF, 8'h00);
        queue_access(OP_READ,  16'hA000, 8'h00);
        queue_access(OP_WRITE, 16'h0000, 8'h0A);
        queue_access(OP_WRITE, 16'hA000, 8'h55);
        queue_access(OP_READ,  16'hA000, 8'h00);
        // Writing zero, and values whose low five bits are zero, selects bank 1.
        queue_access(OP_WRITE, 16'h2000, 8'h00);
        queue_access(OP_READ,  16'h4000, 8'h00);
        queue_access(OP_WRITE, 16'h3FFF, 8'h1F);
        queue_access(OP_READ,  16'h7FFF, 8'h00);
        queue_access(OP_WRITE, 16'h2000, 8'h60);
        queue_access(OP_READ,  16'h8000, 8'h00);
        queue_access(OP_READ,  16'hFFFF, 8'h00);
        // In mode 0 the bank write is only recorded; mode 1 then loads it.
        queue_access(OP_WRITE, 16'h4000, 8'h03);
        queue_access(OP_READ,  16'hBFFF, 8'h00);
        queue_access(OP_WRITE, 16'h6000, 8'h01);
        queue_access(OP_WRITE, 16'hBFFF, 8'hFF);
        queue_access(OP_READ,  16'hBFFF, 8'h00);
        queue_access(OP_WRITE, 16'h7FFF, 8'h00);
        queue_access(OP_READ,  16'hBFFF, 8'h00);
        queue_access(OP_WRITE, 16'hE000, 8'h12);
        queue_access(OP_WRITE, 16'h0000, 8'h00);
        queue_access(OP_READ,  16'hA000, 8'h00);
        queue_random_accesses(250);

        run_phase(1'b1, 1'b0, RAM_CODE_ONE_BANK, 250, 1'b1, 1'b0);
        run_phase(1'b0, 1'b1, 8'd0, 200, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 8'hFF, 250, 1'b1, 1'b1);
        run_phase(1'b1, 1'b1, RAM_CODE_16_BANKS, 250, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, RAM_CODE_8_BANKS, 250, 1'b1, 1'b0);
        run_phase(1'b1, 1'b0, 8'($urandom_range(0, 255)), 250, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, RAM_CODE_4_BANKS, 300, 1'b0, 1'b0);

        wait_for_drain();
        repeat (8) @(posedge aclk);
        $display("%0d bus accesses checked over %0d register settings, %0d save requests.",
                 results_checked, settings_used, saves_seen);
        $display("Flat ROM, bank switching, RAM sizes and a %0d-cycle output stall were run.",
                 LONG_HOLD);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[cartridge_bank_controller.f]
rtl/cbc_pkg.sv
rtl/cbc_mapper.sv
rtl/cartridge_bank_controller.sv
tb/sv/cartridge_bank_controller_test.sv
